@@ sv/tlq_pkg.sv @@
// Shared types and constants for the thick line quad setup block.
// Holds the sequencer state type, command codes and the CORDIC arctangent table.
package tlq_pkg;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_VEC,
		ST_ANG,
		ST_WMUL,
		ST_WSUM,
		ST_PRE,
		ST_ROT,
		ST_RND,
		ST_CORN,
		ST_BOX,
		ST_OUT
	} state_t;

	localparam logic CMD_MOVE = 1'b0;
	localparam logic CMD_LINE = 1'b1;

	localparam int AtanEntries = 24;
	localparam logic signed [27:0] AngQuarter = 28'sd16777216;
	localparam logic signed [27:0] AngHalf = 28'sd33554432;
	localparam logic [15:0] InvGain = 16'd39796;

	localparam logic [23:0] REG_WH = 24'd0;

	function automatic logic [23:0] atan_lut(input logic [4:0] i);
		logic [23:0] v;
		begin
			case (i)
				5'd0: v = 24'd8388608;
				5'd1: v = 24'd4952084;
				5'd2: v = 24'd2616545;
				5'd3: v = 24'd1328199;
				5'd4: v = 24'd666677;
				5'd5: v = 24'd333664;
				5'd6: v = 24'd166872;
				5'd7: v = 24'd83441;
				5'd8: v = 24'd41721;
				5'd9: v = 24'd20860;
				5'd10: v = 24'd10430;
				5'd11: v = 24'd5215;
				5'd12: v = 24'd2608;
				5'd13: v = 24'd1304;
				5'd14: v = 24'd652;
				5'd15: v = 24'd326;
				5'd16: v = 24'd163;
				5'd17: v = 24'd81;
				5'd18: v = 24'd41;
				5'd19: v = 24'd20;
				5'd20: v = 24'd10;
				5'd21: v = 24'd5;
				5'd22: v = 24'd3;
				5'd23: v = 24'd1;
				default: v = 24'd0;
			endcase
			return v;
		end
	endfunction

endpackage

@@ sv/tlq_cordic.sv @@
// Shared CORDIC micro-rotation unit, used for vectoring and for rotation.
// Depends on tlq_pkg for the arctangent table.
module tlq_cordic #(
	parameter int W = 48
) (
	input  logic                clk,
	input  logic                load,
	input  logic                step,
	input  logic                vec_mode,
	input  logic signed [W-1:0] x_in,
	input  logic signed [W-1:0] y_in,
	input  logic signed [27:0]  z_in,
	input  logic [4:0]          idx,
	output logic signed [W-1:0] x_q,
	output logic signed [W-1:0] y_q,
	output logic signed [27:0]  z_q
);
	import tlq_pkg::*;

	logic dir_pos;
	logic signed [27:0] a;

	assign dir_pos = vec_mode ? (y_q > 0) : (z_q >= 0);
	assign a = 28'(signed'({1'b0, atan_lut(idx)}));

	always_ff @(posedge clk) begin
		if (load) begin
			x_q <= x_in;
			y_q <= y_in;
			z_q <= z_in;
		end else if (step) begin
			if (dir_pos ^ ~vec_mode) begin
				x_q <= x_q + (y_q >>> idx);
				y_q <= y_q - (x_q >>> idx);
			end else begin
				x_q <= x_q - (y_q >>> idx);
				y_q <= y_q + (x_q >>> idx);
			end
			if (dir_pos ^ ~vec_mode) z_q <= z_q + a;
			else z_q <= z_q - a;
		end
	end
endmodule

@@ sv/thick_line_quad_setup.sv @@
// Top level of the thick line quad setup block: sequencer, registers, corners.
// Depends on tlq_pkg and tlq_cordic.
//
// channel | direction | signals
// cmd     | in        | in_valid, in_stall, cmd, point_x, point_y
// corner  | out       | out_valid, out_stall, corner_index..last
// config  | in        | psel, penable, pwrite, paddr, pwdata, prdata, pready
//
// A line vectors (dx, dy) and then rotates its thickness through the shared
// CORDIC unit, then hands out four corner transactions. Axis-aligned or
// zero-length lines skip vectoring. A move only updates the cursor.
// Reset clears the sequencer and cursor and sets both width registers to 256.
// in_stall is high whenever an item is in work; out_stall holds the current
// corner.
module thick_line_quad_setup #(
	parameter int COORD_BITS = 24,
	parameter int CORDIC_STEPS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         cmd,
	input  logic signed [COORD_BITS-1:0] point_x,
	input  logic signed [COORD_BITS-1:0] point_y,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [1:0]                   corner_index,
	output logic signed [COORD_BITS-1:0] corner_x,
	output logic signed [COORD_BITS-1:0] corner_y,
	output logic signed [COORD_BITS-1:0] box_left,
	output logic signed [COORD_BITS-1:0] box_top,
	output logic signed [COORD_BITS-1:0] box_right,
	output logic signed [COORD_BITS-1:0] box_bottom,
	output logic                         last,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [2:0]                   paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);
	import tlq_pkg::*;

	localparam int CB = COORD_BITS;
	localparam int DW = CB + 1;
	localparam int W = DW + 19;
	localparam int NST = (CORDIC_STEPS > AtanEntries) ? AtanEntries : CORDIC_STEPS;
	localparam logic signed [CB+1:0] SatHi = (CB+2)'((64'sd1 <<< (CB-1)) - 1);
	localparam logic signed [CB+1:0] SatLo = -SatHi - 1;

	state_t state_q, state_n;
	logic [15:0] wh_q, wv_q;
	logic signed [CB-1:0] cur_x_q, cur_y_q, px_q, py_q;
	logic signed [DW-1:0] dx_q, dy_q;
	logic [4:0] idx_q;
	logic [4:0] c_idx;
	logic [1:0] k_q;
	logic signed [27:0] base_q, ang_q;
	logic neg_q;
	logic [40:0] p1_q, p2_q;
	logic [15:0] thick_q;
	logic signed [DW+1:0] co_q, si_q;
	logic signed [CB-1:0] cx_q [4];
	logic signed [CB-1:0] cy_q [4];
	logic signed [CB-1:0] l_q, t_q, r_q, b_q;

	logic c_load, c_step, c_vec;
	logic signed [W-1:0] cx_in, cy_in, c_x, c_y;
	logic signed [27:0] cz_in, c_z;
	logic acc_in, acc_out, cfg_wr;

	assign c_idx = (state_q == ST_VEC) ? idx_q - 5'd1 : idx_q;

	tlq_cordic #(.W(W)) u_cordic (
		.clk(clk), .load(c_load), .step(c_step), .vec_mode(c_vec),
		.x_in(cx_in), .y_in(cy_in), .z_in(cz_in), .idx(c_idx),
		.x_q(c_x), .y_q(c_y), .z_q(c_z)
	);

	assign acc_in = in_valid && !in_stall;
	assign acc_out = out_valid && !out_stall;
	assign cfg_wr = psel && penable && pwrite;
	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? {16'd0, wh_q} : {16'd0, wv_q};

	logic dx_neg, dx_zero, dy_zero;
	assign dx_neg = dx_q[DW-1];
	assign dx_zero = (dx_q == '0);
	assign dy_zero = (dy_q == '0);

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE: if (acc_in && cmd == CMD_LINE) state_n = ST_VEC;
			ST_VEC:  if (dx_zero || dy_zero || idx_q == 5'(NST)) state_n = ST_ANG;
			ST_ANG:  state_n = ST_WMUL;
			ST_WMUL: state_n = ST_WSUM;
			ST_WSUM: state_n = ST_PRE;
			ST_PRE:  state_n = ST_ROT;
			ST_ROT:  if (idx_q == 5'(NST - 1)) state_n = ST_RND;
			ST_RND:  state_n = ST_CORN;
			ST_CORN: state_n = ST_BOX;
			ST_BOX:  state_n = ST_OUT;
			ST_OUT:  if (acc_out && k_q == 2'd3) state_n = ST_IDLE;
			default: state_n = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_stall = (state_q != ST_IDLE);
		out_valid = (state_q == ST_OUT);
		c_load = 1'b0;
		c_step = 1'b0;
		c_vec = 1'b1;
		cx_in = '0;
		cy_in = '0;
		cz_in = '0;
		unique case (state_q)
			ST_VEC: begin
				c_step = !(dx_zero || dy_zero) && idx_q != 5'd0;
				c_load = idx_q == 5'd0;
				cx_in = W'(dx_neg ? -dx_q : dx_q) <<< 16;
				cy_in = W'(dx_neg ? -dy_q : dy_q) <<< 16;
			end
			ST_PRE: begin
				c_load = 1'b1;
				c_vec = 1'b0;
				cx_in = W'(signed'({1'b0, 32'(thick_q) * 32'(InvGain)}));
				cz_in = (ang_q > AngQuarter) ? ang_q - AngHalf :
					(ang_q < -AngQuarter) ? ang_q + AngHalf : ang_q;
			end
			ST_ROT: begin
				c_step = 1'b1;
				c_vec = 1'b0;
			end
			default: ;
		endcase
	end

	logic signed [27:0] zfin, g0, g1;
	logic signed [W-1:0] rx, ry;
	assign zfin = c_z + base_q;
	assign g0 = ang_q[27] ? -ang_q : ang_q;
	assign g1 = (g0 > AngQuarter) ? AngHalf - g0 : g0;
	assign rx = (c_x + W'(65536)) >>> 17;
	assign ry = (c_y + W'(65536)) >>> 17;

	function automatic logic signed [CB-1:0] sat_f(input logic signed [CB+1:0] v);
		return (v > SatHi) ? SatHi[CB-1:0] : (v < SatLo) ? SatLo[CB-1:0] : v[CB-1:0];
	endfunction

	logic signed [CB+1:0] e0x, e0y, e3x, e3y;
	assign e0x = (CB+2)'(cur_x_q) + (CB+2)'(si_q);
	assign e0y = (CB+2)'(cur_y_q) - (CB+2)'(co_q);
	assign e3x = (CB+2)'(cur_x_q) - (CB+2)'(si_q);
	assign e3y = (CB+2)'(cur_y_q) + (CB+2)'(co_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			wh_q <= 16'd256;
			wv_q <= 16'd256;
			cur_x_q <= '0;
			cur_y_q <= '0;
			idx_q <= '0;
			k_q <= '0;
		end else begin
			state_q <= state_n;
			if (cfg_wr) begin
				if (paddr[2] == REG_WH[0]) wh_q <= pwdata[15:0];
				else wv_q <= pwdata[15:0];
			end
			unique case (state_q)
				ST_IDLE: begin
					idx_q <= '0;
					k_q <= '0;
					if (acc_in && cmd == CMD_MOVE) begin
						cur_x_q <= point_x;
						cur_y_q <= point_y;
					end
				end
				ST_VEC, ST_ROT:
					idx_q <= (state_n == state_q) ? idx_q + 5'd1 : 5'd0;
				ST_OUT: if (acc_out) begin
					k_q <= k_q + 2'd1;
					if (k_q == 2'd3) begin
						cur_x_q <= px_q;
						cur_y_q <= py_q;
					end
				end
				default: ;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (acc_in) begin
			px_q <= point_x;
			py_q <= point_y;
			dx_q <= DW'(point_x) - DW'(cur_x_q);
			dy_q <= DW'(point_y) - DW'(cur_y_q);
		end
		case (state_q)
			ST_VEC: if (idx_q == 5'd0)
				base_q <= !dx_neg ? 28'sd0 : (dy_q[DW-1] ? -AngHalf : AngHalf);
			ST_ANG: begin
				if (dy_zero) ang_q <= dx_neg ? AngHalf : 28'sd0;
				else if (dx_zero) ang_q <= dy_q[DW-1] ? -AngQuarter : AngQuarter;
				else if (zfin > AngHalf) ang_q <= AngHalf;
				else if (zfin < -AngHalf) ang_q <= -AngHalf;
				else ang_q <= zfin;
			end
			ST_WMUL: begin
				p1_q <= 41'(wh_q) * 41'(g1[24:0]);
				p2_q <= 41'(wv_q) * 41'(AngQuarter[24:0] - g1[24:0]);
			end
			ST_WSUM: thick_q <= 16'((p1_q + p2_q + 41'd8388608) >> 24);
			ST_PRE: neg_q <= (ang_q > AngQuarter) || (ang_q < -AngQuarter);
			ST_RND: begin
				co_q <= neg_q ? -(DW+2)'(rx) : (DW+2)'(rx);
				si_q <= neg_q ? -(DW+2)'(ry) : (DW+2)'(ry);
			end
			ST_CORN: begin
				cx_q[0] <= sat_f(e0x);
				cy_q[0] <= sat_f(e0y);
				cx_q[1] <= sat_f(e0x + (CB+2)'(dx_q));
				cy_q[1] <= sat_f(e0y + (CB+2)'(dy_q));
				cx_q[3] <= sat_f(e3x);
				cy_q[3] <= sat_f(e3y);
				cx_q[2] <= sat_f(e3x + (CB+2)'(dx_q));
				cy_q[2] <= sat_f(e3y + (CB+2)'(dy_q));
			end
			ST_BOX: begin
				// take the extents of c0 and c3 here, fold in c1 and c2 below
				l_q <= (cx_q[0] < cx_q[3] ? cx_q[0] : cx_q[3]);
				r_q <= (cx_q[0] > cx_q[3] ? cx_q[0] : cx_q[3]);
				t_q <= (cy_q[0] < cy_q[3] ? cy_q[0] : cy_q[3]);
				b_q <= (cy_q[0] > cy_q[3] ? cy_q[0] : cy_q[3]);
			end
			default: ;
		endcase
	end

	logic signed [CB-1:0] mnx, mxx, mny, mxy;
	always_comb begin
		mnx = l_q; mxx = r_q; mny = t_q; mxy = b_q;
		if (cx_q[1] < mnx) mnx = cx_q[1];
		if (cx_q[2] < mnx) mnx = cx_q[2];
		if (cx_q[1] > mxx) mxx = cx_q[1];
		if (cx_q[2] > mxx) mxx = cx_q[2];
		if (cy_q[1] < mny) mny = cy_q[1];
		if (cy_q[2] < mny) mny = cy_q[2];
		if (cy_q[1] > mxy) mxy = cy_q[1];
		if (cy_q[2] > mxy) mxy = cy_q[2];
	end

	assign corner_index = k_q;
	assign corner_x = cx_q[k_q];
	assign corner_y = cy_q[k_q];
	assign box_left = mnx;
	assign box_right = mxx;
	assign box_top = mny;
	assign box_bottom = mxy;
	assign last = (k_q == 2'd3);

`ifndef SYNTHESIS
	a_no_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> in_stall) else $error("input taken while busy");
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(acc_out && last) |=> (state_q == ST_IDLE)) else $error("no return to idle");
	a_hold_corner: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> $stable(corner_index)) else $error("corner moved");
`endif
endmodule
